// ===== hw/rtl/pqem_pkg.sv =====
package pqem_pkg;

  // Number of entries the queue can hold.
  localparam int unsigned CAPACITY = 16;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned PRI_W   = 8;
  localparam int unsigned OCC_W   = 5;
  localparam int unsigned ENTRY_W = PRI_W + VAL_W;
  localparam int unsigned IDX_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W   = $clog2(CAPACITY + 1);

  localparam logic signed [VAL_W-1:0] NONE_VALUE = -VAL_W'(1);

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_EXTRACT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_SHIFT,
    S_RESULT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    do_insert;
    logic    scan_start;
    logic    scan_phase;
    logic    shift_start;
    logic    shift_phase;
    logic    rd_issue;
    logic    count_dec;
    logic    res_load;
    logic    res_from_best;
    status_e res_status;
    logic    load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_extract;
    logic empty;
    logic full;
    logic idx_at_end;
    logic rd_pend;
  } sts_t;

endpackage

// ===== hw/rtl/pqem_ctrl.sv =====
module pqem_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  input  pqem_pkg::sts_t  sts_i,
  output pqem_pkg::cmd_t  cmd_o
);

  pqem_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pqem_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pqem_pkg::S_IDLE: begin
        if (in_valid_i) state_d = pqem_pkg::S_EXEC;
      end
      pqem_pkg::S_EXEC: begin
        if (sts_i.is_extract && !sts_i.empty) state_d = pqem_pkg::S_SCAN;
        else state_d = pqem_pkg::S_RESULT;
      end
      pqem_pkg::S_SCAN: begin
        if (sts_i.idx_at_end && !sts_i.rd_pend) state_d = pqem_pkg::S_SHIFT;
      end
      pqem_pkg::S_SHIFT: begin
        if (sts_i.idx_at_end && !sts_i.rd_pend) state_d = pqem_pkg::S_RESULT;
      end
      pqem_pkg::S_RESULT: begin
        if (!out_valid_q || !out_stall_i) state_d = pqem_pkg::S_IDLE;
      end
      default: state_d = pqem_pkg::S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o            = '0;
    cmd_o.res_status = pqem_pkg::ST_OK;
    in_stall_o       = 1'b1;
    case (state_q)
      pqem_pkg::S_IDLE: begin
        in_stall_o      = 1'b0;
        cmd_o.load_item = in_valid_i;
      end
      pqem_pkg::S_EXEC: begin
        if (!sts_i.is_extract) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.do_insert  = !sts_i.full;
          cmd_o.res_status = sts_i.full ? pqem_pkg::ST_FULL : pqem_pkg::ST_OK;
        end else if (sts_i.empty) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = pqem_pkg::ST_EMPTY;
        end else begin
          cmd_o.scan_start = 1'b1;
        end
      end
      pqem_pkg::S_SCAN: begin
        cmd_o.scan_phase = 1'b1;
        cmd_o.rd_issue   = !sts_i.idx_at_end;
        if (sts_i.idx_at_end && !sts_i.rd_pend) begin
          cmd_o.shift_start   = 1'b1;
          cmd_o.res_load      = 1'b1;
          cmd_o.res_from_best = 1'b1;
        end
      end
      pqem_pkg::S_SHIFT: begin
        cmd_o.shift_phase = 1'b1;
        cmd_o.rd_issue    = !sts_i.idx_at_end;
        cmd_o.count_dec   = sts_i.idx_at_end && !sts_i.rd_pend;
      end
      pqem_pkg::S_RESULT: begin
        cmd_o.load_out = !out_valid_q || !out_stall_i;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/pqem_dp.sv =====
module pqem_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  opcode_i,
  input  logic signed [pqem_pkg::VAL_W-1:0]     item_value_i,
  input  logic        [pqem_pkg::PRI_W-1:0]     item_priority_i,
  input  pqem_pkg::cmd_t                        cmd_i,
  output pqem_pkg::sts_t                        sts_o,
  output logic signed [pqem_pkg::VAL_W-1:0]     removed_value_o,
  output logic        [1:0]                     status_o,
  output logic        [pqem_pkg::OCC_W-1:0]     occupancy_o
);

  // Entry store: priority in the upper bits, value in the lower bits.
  logic [pqem_pkg::ENTRY_W-1:0] mem_q [pqem_pkg::CAPACITY];
  logic [pqem_pkg::ENTRY_W-1:0] rd_data_q;

  logic                          wr_en;
  logic [pqem_pkg::IDX_W-1:0]    wr_addr;
  logic [pqem_pkg::ENTRY_W-1:0]  wr_data;
  logic [pqem_pkg::IDX_W-1:0]    rd_addr;

  logic [pqem_pkg::CNT_W-1:0]    count_q;
  logic [pqem_pkg::CNT_W-1:0]    idx_q;
  logic                          rd_vld_q;
  logic [pqem_pkg::IDX_W-1:0]    rd_tag_q;

  pqem_pkg::op_e                 item_op_q;
  logic signed [pqem_pkg::VAL_W-1:0] item_val_q;
  logic [pqem_pkg::PRI_W-1:0]    item_pri_q;

  logic [pqem_pkg::IDX_W-1:0]    best_idx_q;
  logic [pqem_pkg::PRI_W-1:0]    best_pri_q;
  logic signed [pqem_pkg::VAL_W-1:0] best_val_q;

  logic signed [pqem_pkg::VAL_W-1:0] res_val_q;
  pqem_pkg::status_e             res_st_q;

  logic signed [pqem_pkg::VAL_W-1:0] out_val_q;
  logic [1:0]                    out_st_q;
  logic [pqem_pkg::OCC_W-1:0]    out_occ_q;

  logic [pqem_pkg::PRI_W-1:0]    rd_pri;
  logic signed [pqem_pkg::VAL_W-1:0] rd_val;
  logic                          take_best;

  assign rd_pri = rd_data_q[pqem_pkg::ENTRY_W-1 -: pqem_pkg::PRI_W];
  assign rd_val = rd_data_q[pqem_pkg::VAL_W-1:0];

  // The first entry always seeds the maximum; later ones replace it only
  // when strictly greater, so the oldest entry wins a tie.
  assign take_best = cmd_i.scan_phase && rd_vld_q &&
                     ((rd_tag_q == '0) || (rd_pri > best_pri_q));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = count_q[pqem_pkg::IDX_W-1:0];
    wr_data = {item_pri_q, item_val_q};
    if (cmd_i.do_insert) begin
      wr_en = 1'b1;
    end else if (cmd_i.shift_phase && rd_vld_q) begin
      wr_en   = 1'b1;
      wr_addr = rd_tag_q - pqem_pkg::IDX_W'(1);
      wr_data = rd_data_q;
    end
  end

  assign rd_addr = idx_q[pqem_pkg::IDX_W-1:0];

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (cmd_i.rd_issue) rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      if (cmd_i.do_insert) count_q <= count_q + pqem_pkg::CNT_W'(1);
      else if (cmd_i.count_dec) count_q <= count_q - pqem_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_op_q  <= pqem_pkg::op_e'(opcode_i);
      item_val_q <= item_value_i;
      item_pri_q <= item_priority_i;
    end
    if (cmd_i.scan_start) idx_q <= '0;
    else if (cmd_i.shift_start)
      idx_q <= pqem_pkg::CNT_W'(best_idx_q) + pqem_pkg::CNT_W'(1);
    else if (cmd_i.rd_issue) idx_q <= idx_q + pqem_pkg::CNT_W'(1);
    if (cmd_i.rd_issue) rd_tag_q <= rd_addr;
    if (take_best) begin
      best_idx_q <= rd_tag_q;
      best_pri_q <= rd_pri;
      best_val_q <= rd_val;
    end
    if (cmd_i.res_load) begin
      res_val_q <= cmd_i.res_from_best ? best_val_q : pqem_pkg::NONE_VALUE;
      res_st_q  <= cmd_i.res_status;
    end
    if (cmd_i.load_out) begin
      out_val_q <= res_val_q;
      out_st_q  <= res_st_q;
      out_occ_q <= pqem_pkg::OCC_W'(count_q);
    end
  end

  assign sts_o.is_extract = (item_op_q == pqem_pkg::OP_EXTRACT);
  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q == pqem_pkg::CNT_W'(pqem_pkg::CAPACITY));
  assign sts_o.idx_at_end = (idx_q == count_q);
  assign sts_o.rd_pend    = rd_vld_q;

  assign removed_value_o = out_val_q;
  assign status_o        = out_st_q;
  assign occupancy_o     = out_occ_q;

endmodule

// ===== hw/rtl/priority_queue_extract_max.sv =====
// Bounded max-priority queue of 16 entries held unsorted in arrival order in
// a single-port-write, registered-read memory. Each accepted item produces
// exactly one result transfer. An insert writes its entry and registers its
// result, then presents it, and the next item can be accepted after that.
// An extract first scans the held entries for the highest priority (one
// memory read per cycle, with the oldest entry winning a tie). It then
// closes the gap behind the removed slot, moving entries one per cycle
// through the same read port, and then presents the result.
// The block handles one item at a time, but a finished result sits in an
// output register so the next item can be accepted while it waits.
// Extract on an empty queue returns -1 with the empty status, an insert into
// a full queue is dropped with the full status, and every insert reports -1
// as its removed value.
module priority_queue_extract_max (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              opcode_i,
  input  logic signed [pqem_pkg::VAL_W-1:0] item_value_i,
  input  logic        [pqem_pkg::PRI_W-1:0] item_priority_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [pqem_pkg::VAL_W-1:0] removed_value_o,
  output logic        [1:0]                 status_o,
  output logic        [pqem_pkg::OCC_W-1:0] occupancy_o
);

  // The controller sequences insert, scan and compaction; the datapath owns
  // the entry store, the counters and the result registers.
  pqem_pkg::cmd_t cmd;
  pqem_pkg::sts_t sts;

  pqem_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pqem_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .item_value_i    (item_value_i),
    .item_priority_i (item_priority_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

endmodule

// ===== tb/sv/tb_priority_queue_extract_max.sv =====
`timescale 1ns / 1ps

typedef struct {
  logic signed [pqem_pkg::VAL_W-1:0] removed_value;
  pqem_pkg::status_e                 status;
  logic        [pqem_pkg::OCC_W-1:0] occupancy;
} pq_result_t;

// Tracks the queue contents and the results still owed by the block.
class pq_scoreboard;
  logic signed [pqem_pkg::VAL_W-1:0] held_value[$];
  logic        [pqem_pkg::PRI_W-1:0] held_prio[$];
  pq_result_t                        expected_results[$];
  int unsigned                       mismatches;

  function new();
    mismatches = 0;
  endfunction

  // Applies one accepted operation to the queue and records the result it owes.
  function void apply_operation(pqem_pkg::op_e op,
                                logic signed [pqem_pkg::VAL_W-1:0] value,
                                logic [pqem_pkg::PRI_W-1:0] prio);
    pq_result_t res;
    int         best;
    res.removed_value = pqem_pkg::NONE_VALUE;
    res.status        = pqem_pkg::ST_OK;
    if (op == pqem_pkg::OP_INSERT) begin
      if (held_value.size() >= pqem_pkg::CAPACITY) begin
        res.status = pqem_pkg::ST_FULL;
      end else begin
        held_value.push_back(value);
        held_prio.push_back(prio);
      end
    end else if (held_value.size() == 0) begin
      res.status = pqem_pkg::ST_EMPTY;
    end else begin
      // Strictly greater only, so the oldest entry wins a tie.
      best = 0;
      for (int i = 1; i < held_value.size(); i++) begin
        if (held_prio[i] > held_prio[best]) best = i;
      end
      res.removed_value = held_value[best];
      held_value.delete(best);
      held_prio.delete(best);
    end
    res.occupancy = pqem_pkg::OCC_W'(held_value.size());
    expected_results.push_back(res);
  endfunction

  function void check_result(logic signed [pqem_pkg::VAL_W-1:0] removed_value,
                             logic [1:0] status,
                             logic [pqem_pkg::OCC_W-1:0] occupancy);
    pq_result_t want;
    if (expected_results.size() == 0) begin
      $display("%0t: unexpected result: removed_value %0d status %0d occupancy %0d",
               $time, removed_value, status, occupancy);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    if (removed_value !== want.removed_value || status !== want.status ||
        occupancy !== want.occupancy) begin
      $display("%0t: result mismatch: expected removed_value %0d status %0d occupancy %0d",
               $time, want.removed_value, want.status, want.occupancy);
      $display("%0t: result mismatch: got removed_value %0d status %0d occupancy %0d",
               $time, removed_value, status, occupancy);
      mismatches++;
    end
  endfunction
endclass

module tb_priority_queue_extract_max;

  logic                              clk_i         = 1'b0;
  logic                              rst_ni        = 1'b0;
  logic                              in_valid      = 1'b0;
  logic                              in_stall_o;
  logic                              opcode        = pqem_pkg::OP_INSERT;
  logic signed [pqem_pkg::VAL_W-1:0] item_value    = '0;
  logic        [pqem_pkg::PRI_W-1:0] item_prio     = '0;
  logic                              out_valid_o;
  logic                              out_stall     = 1'b0;
  logic signed [pqem_pkg::VAL_W-1:0] removed_value_o;
  logic        [1:0]                 status_o;
  logic        [pqem_pkg::OCC_W-1:0] occupancy_o;

  // Percentages of cycles in which the sender holds back an item and the
  // receiver refuses a result. The phases of the random part change them.
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;

  // Idle and stall percentages per phase: none, sender only, receiver only, both.
  int unsigned idle_plan[4]  = '{0, 55, 0, 37};
  int unsigned stall_plan[4] = '{0, 0, 55, 37};
  // Insert share for each stretch of a phase. A heavy insert stretch drives the
  // queue to full, a light one drains it to empty, so both ends are reached.
  int unsigned insert_plan[4] = '{85, 50, 15, 60};

  pq_scoreboard sb;

  priority_queue_extract_max dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall_o),
    .opcode_i        (opcode),
    .item_value_i    (item_value),
    .item_priority_i (item_prio),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall),
    .removed_value_o (removed_value_o),
    .status_o        (status_o),
    .occupancy_o     (occupancy_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // The receiver stalls at random; the rate follows the current phase.
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Both channels are sampled at the rising edge, before any of this edge's
  // updates land. An input transfer is applied to the queue before a result
  // transfer at the same edge is checked; a result can never belong to an item
  // accepted at that very edge, so the order is safe.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        sb.apply_operation(pqem_pkg::op_e'(opcode), item_value, item_prio);
      end
      if (out_valid_o && !out_stall) begin
        sb.check_result(removed_value_o, status_o, occupancy_o);
      end
    end
  end

  // Presents one item, after a random number of idle cycles, and returns just
  // after the edge at which it was transferred. Valid stays high when the next
  // item follows without a gap, so it is never dropped and raised in one step.
  task automatic send_item(input pqem_pkg::op_e op,
                           input logic signed [pqem_pkg::VAL_W-1:0] value,
                           input logic [pqem_pkg::PRI_W-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    item_value <= value;
    item_prio  <= prio;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // A random item. Values lean toward the sign extremes, and priorities are
  // often drawn from a tiny range or the two ends, so ties are common and the
  // oldest-wins rule gets exercised. Extracts carry random payload as well,
  // since the block must ignore it.
  task automatic send_random_item(input int unsigned insert_pct);
    pqem_pkg::op_e                     op;
    logic signed [pqem_pkg::VAL_W-1:0] value;
    logic        [pqem_pkg::PRI_W-1:0] prio;
    if ($urandom_range(99) < insert_pct) op = pqem_pkg::OP_INSERT;
    else op = pqem_pkg::OP_EXTRACT;
    case ($urandom_range(7))
      0: value = {1'b1, {(pqem_pkg::VAL_W-1){1'b0}}};
      1: value = {1'b0, {(pqem_pkg::VAL_W-1){1'b1}}};
      2: value = pqem_pkg::NONE_VALUE;
      3: value = '0;
      default: value = $urandom;
    endcase
    case ($urandom_range(3))
      0: prio = pqem_pkg::PRI_W'($urandom_range(3));
      1: prio = $urandom_range(1) ? '1 : '0;
      default: prio = pqem_pkg::PRI_W'($urandom);
    endcase
    send_item(op, value, prio);
  endtask

  initial begin
    sb = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, with no idling on either side.
    // An extract right after reset finds the queue empty; its payload is junk.
    send_item(pqem_pkg::OP_EXTRACT, 32'sh1234_5678, 8'hAB);
    // Value and priority extremes, with the top priority given twice so that
    // the first extract has to pick the older of two equal entries.
    send_item(pqem_pkg::OP_INSERT, {1'b1, {(pqem_pkg::VAL_W-1){1'b0}}}, 8'h00);
    send_item(pqem_pkg::OP_INSERT, {1'b0, {(pqem_pkg::VAL_W-1){1'b1}}}, 8'hFF);
    send_item(pqem_pkg::OP_INSERT, pqem_pkg::NONE_VALUE, 8'h80);
    send_item(pqem_pkg::OP_INSERT, '0, 8'hFF);
    send_item(pqem_pkg::OP_EXTRACT, '0, '0);
    send_item(pqem_pkg::OP_EXTRACT, pqem_pkg::NONE_VALUE, 8'hFF);
    // Two entries remain; fill the other fourteen slots with alternating bit
    // patterns, then one more insert must be dropped as full.
    for (int i = 0; i < pqem_pkg::CAPACITY - 2; i++) begin
      send_item(pqem_pkg::OP_INSERT,
                (i % 2) ? 32'shAAAA_AAAA + i : 32'sh5555_5555 + i,
                (i % 2) ? 8'hAA : 8'h55);
    end
    send_item(pqem_pkg::OP_INSERT, 32'sh0BAD_0BAD, 8'hFF);
    // Extract from a full queue: the oldest of the highest entries goes.
    send_item(pqem_pkg::OP_EXTRACT, '0, '0);

    // Random part: four idling phases of a hundred items, each split into
    // stretches with a different share of inserts.
    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct  = idle_plan[phase];
      recv_stall_pct = stall_plan[phase];
      for (int n = 0; n < 100; n++) begin
        send_random_item(insert_plan[n / 25]);
      end
    end
    in_valid <= 1'b0;

    // Wait for every owed result, then a little longer than the slowest
    // extract so that any extra result would still show up.
    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far longer than the slowest correct run with every stall.
  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
